>>> src/mlbwg_pkg.sv
package mlbwg_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int GRID_NODES = 4096;
  localparam int POS_W      = 32;
  localparam int NODE_W     = 12;
  localparam int INV_W      = 31;
  localparam int BASE_W     = $clog2(GRID_NODES);
  localparam int DIFF_W     = POS_W + 1;
  localparam int HI_W       = DIFF_W - FRAC_BITS;
  localparam int LO_PROD_W  = FRAC_BITS + INV_W;
  localparam int T_W        = HI_W + INV_W + 1;
  localparam int N_W        = FRAC_BITS + 1;
  localparam int WEIGHT_W   = 17;
  localparam int GRAD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 2'd2;

  localparam logic [INV_W-1:0] INV_RESET = INV_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic [NODE_W-1:0]     nx;
    logic [NODE_W-1:0]     ny;
  } cell_t;

  typedef enum logic [1:0] {
    SLOPE_ZERO,
    SLOPE_NEG,
    SLOPE_POS
  } slope_e;

endpackage

>>> src/mlbwg_front.sv
module mlbwg_front import mlbwg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic [NODE_W-1:0]       node_x_i,
  input  logic [NODE_W-1:0]       node_y_i,
  input  logic signed [POS_W-1:0] origin_x_i,
  input  logic signed [POS_W-1:0] origin_y_i,
  input  logic [INV_W-1:0]        inv_i,
  output logic                    push_o,
  output cell_t                   cell_o
);

  logic                     v0_q, v1_q;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [NODE_W-1:0]        nx0_q, ny0_q, nx1_q, ny1_q;
  logic signed [HI_W-1:0]   hx, hy;
  logic signed [T_W-1:0]    hpx_d, hpy_d, hpx_q, hpy_q;
  logic [LO_PROD_W-1:0]     lpx_d, lpy_d, lpx_q, lpy_q;

  assign dx_d = {pos_x_i[POS_W-1], pos_x_i} - {origin_x_i[POS_W-1], origin_x_i};
  assign dy_d = {pos_y_i[POS_W-1], pos_y_i} - {origin_y_i[POS_W-1], origin_y_i};

  assign hx = dx_q[DIFF_W-1:FRAC_BITS];
  assign hy = dy_q[DIFF_W-1:FRAC_BITS];

  // The difference is split into a signed upper part and an unsigned fraction.
  assign hpx_d = hx * $signed({1'b0, inv_i});
  assign hpy_d = hy * $signed({1'b0, inv_i});
  assign lpx_d = dx_q[FRAC_BITS-1:0] * inv_i;
  assign lpy_d = dy_q[FRAC_BITS-1:0] * inv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= accept_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    nx0_q <= node_x_i;
    ny0_q <= node_y_i;
    hpx_q <= hpx_d;
    hpy_q <= hpy_d;
    lpx_q <= lpx_d;
    lpy_q <= lpy_d;
    nx1_q <= nx0_q;
    ny1_q <= ny0_q;
  end

  assign push_o    = v1_q;
  assign cell_o.tx = hpx_q + $signed(T_W'(lpx_q[LO_PROD_W-1:FRAC_BITS]));
  assign cell_o.ty = hpy_q + $signed(T_W'(lpy_q[LO_PROD_W-1:FRAC_BITS]));
  assign cell_o.nx = nx1_q;
  assign cell_o.ny = ny1_q;

endmodule

>>> src/mlbwg_queue.sv
module mlbwg_queue import mlbwg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cell_t data_i,
  input  logic  pop_i,
  output logic  empty_o,
  output logic  busy_o,
  output cell_t data_o
);

  cell_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  logic                do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i & ~empty_o;
  // Two items may still be in flight in the front part.
  assign busy_o  = (cnt_q >= (QPTR_W+1)'(QDEPTH - 2));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> src/mlbwg_back.sv
module mlbwg_back import mlbwg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  cell_t                    cell_i,
  input  logic [INV_W-1:0]         inv_i,
  output logic                     valid_o,
  output logic [BASE_W-1:0]        base_x_o,
  output logic [BASE_W-1:0]        base_y_o,
  output logic [WEIGHT_W-1:0]      weight_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o
);

  localparam int B_W = T_W - FRAC_BITS;
  localparam logic signed [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

  function automatic logic [BASE_W-1:0] sat_base(input logic signed [T_W-1:0] t);
    logic [B_W-1:0] b;
    b = t[T_W-1:FRAC_BITS];
    if (b[B_W-1]) begin
      sat_base = '0;
    end else if (b > B_W'(GRID_NODES - 1)) begin
      sat_base = BASE_W'(GRID_NODES - 1);
    end else begin
      sat_base = b[BASE_W-1:0];
    end
  endfunction

  function automatic logic [N_W-1:0] tent(input logic signed [T_W-1:0] d);
    logic signed [T_W-1:0] a;
    logic signed [T_W-1:0] r;
    a = d[T_W-1] ? -d : d;
    r = ONE - a;
    if (a < ONE) begin
      tent = r[N_W-1:0];
    end else begin
      tent = '0;
    end
  endfunction

  function automatic slope_e slope(input logic signed [T_W-1:0] d);
    if (d > ONE || d < -ONE) begin
      slope = SLOPE_ZERO;
    end else if (!d[T_W-1]) begin
      slope = SLOPE_NEG;
    end else begin
      slope = SLOPE_POS;
    end
  endfunction

  function automatic logic [GRAD_W-1:0] apply(input slope_e s, input logic [GRAD_W-1:0] m);
    case (s)
      SLOPE_NEG: apply = -m;
      SLOPE_POS: apply = m;
      default:   apply = '0;
    endcase
  endfunction

  logic signed [T_W-1:0]      ddx, ddy;
  logic                       v0_q, v1_q, v2_q;
  logic [BASE_W-1:0]          bx0_q, by0_q, bx1_q, by1_q, bx2_q, by2_q;
  logic [N_W-1:0]             nx_q, ny_q;
  slope_e                     sx0_q, sy0_q, sx1_q, sy1_q;
  logic [2*N_W-1:0]           wprod;
  logic [N_W+INV_W-1:0]       gxprod, gyprod;
  logic [WEIGHT_W-1:0]        w1_q, w2_q;
  logic [GRAD_W-1:0]          mx_q, my_q, gx2_q, gy2_q;

  assign ddx = cell_i.tx - $signed(T_W'({cell_i.nx, FRAC_BITS'(0)}));
  assign ddy = cell_i.ty - $signed(T_W'({cell_i.ny, FRAC_BITS'(0)}));

  assign wprod  = nx_q * ny_q;
  assign gxprod = ny_q * inv_i;
  assign gyprod = nx_q * inv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bx0_q <= sat_base(cell_i.tx);
    by0_q <= sat_base(cell_i.ty);
    nx_q  <= tent(ddx);
    ny_q  <= tent(ddy);
    sx0_q <= slope(ddx);
    sy0_q <= slope(ddy);

    bx1_q <= bx0_q;
    by1_q <= by0_q;
    sx1_q <= sx0_q;
    sy1_q <= sy0_q;
    w1_q  <= wprod[FRAC_BITS +: WEIGHT_W];
    mx_q  <= gxprod[FRAC_BITS +: GRAD_W];
    my_q  <= gyprod[FRAC_BITS +: GRAD_W];

    bx2_q <= bx1_q;
    by2_q <= by1_q;
    w2_q  <= w1_q;
    gx2_q <= apply(sx1_q, mx_q);
    gy2_q <= apply(sy1_q, my_q);
  end

  assign valid_o  = v2_q;
  assign base_x_o = bx2_q;
  assign base_y_o = by2_q;
  assign weight_o = w2_q;
  assign grad_x_o = gx2_q;
  assign grad_y_o = gy2_q;

endmodule

>>> src/mpm_linear_basis_weight_grad.sv
// A result is strobed on out_valid_o after its item passes the front, queue and back parts.
// Throughput: one item per cycle while busy is low.
// The result ports carry each result for one cycle only, as the receiver cannot stall.
// Reset is asynchronous and active low; it empties the pipeline and the queue and restores
// the configuration registers to origin zero and a reciprocal cell width of one.
module mpm_linear_basis_weight_grad import mlbwg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic [NODE_W-1:0]        node_x_i,
  input  logic [NODE_W-1:0]        node_y_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                     out_valid_o,
  output logic [BASE_W-1:0]        base_x_o,
  output logic [BASE_W-1:0]        base_y_o,
  output logic [WEIGHT_W-1:0]      weight_out_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o
);

  logic signed [POS_W-1:0] origin_x_q, origin_y_q;
  logic [INV_W-1:0]        inv_q;
  logic                    accept, push, q_empty, q_busy;
  cell_t                   push_cell, head_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_q      <= INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_wdata_i[POS_W-1:0];
        CFG_ORIGIN_Y: origin_y_q <= cfg_wdata_i[POS_W-1:0];
        CFG_INV_CELL: inv_q      <= cfg_wdata_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = q_busy;
  assign accept = start & ~q_busy;

  mlbwg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .node_x_i   (node_x_i),
    .node_y_i   (node_y_i),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .inv_i      (inv_q),
    .push_o     (push),
    .cell_o     (push_cell)
  );

  mlbwg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cell),
    .pop_i   (1'b1),
    .empty_o (q_empty),
    .busy_o  (q_busy),
    .data_o  (head_cell)
  );

  mlbwg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (~q_empty),
    .cell_i   (head_cell),
    .inv_i    (inv_q),
    .valid_o  (out_valid_o),
    .base_x_o (base_x_o),
    .base_y_o (base_y_o),
    .weight_o (weight_out_o),
    .grad_x_o (grad_x_o),
    .grad_y_o (grad_y_o)
  );

endmodule
